// ===== rtl/core/sapc_pkg.sv =====
// ----------------------------------------------------------------------------
// sapc_pkg: shared definitions for the servo angle pulse calibrator
// Command and phase codes, calibration constants and the payload structs.
// ----------------------------------------------------------------------------
package sapc_pkg;

	localparam int CmdW   = 3;
	localparam int DegW   = 8;
	localparam int MatchW = 24;
	localparam int WaitW  = 10;
	localparam int PhaseW = 2;

	// Interpolation scale: g = ceil(|span| * 2^FracW / 180), split as quotient and fraction.
	localparam int FracW  = 16;
	localparam int QuotW  = 17;
	localparam int ScaleW = QuotW + FracW;

	// Command codes.
	localparam logic [CmdW-1:0] CmdMove  = 3'd0;
	localparam logic [CmdW-1:0] CmdBegin = 3'd1;
	localparam logic [CmdW-1:0] CmdDown  = 3'd2;
	localparam logic [CmdW-1:0] CmdUp    = 3'd3;
	localparam logic [CmdW-1:0] CmdSet   = 3'd4;

	// Calibration phases.
	localparam logic [PhaseW-1:0] PhaseIdle = 2'd0;
	localparam logic [PhaseW-1:0] PhaseZero = 2'd1;
	localparam logic [PhaseW-1:0] PhaseFull = 2'd2;

	localparam logic [DegW-1:0]   MaxDeg    = 8'd180;
	localparam logic [DegW-1:0]   MidDeg    = 8'd90;
	localparam logic [MatchW-1:0] StepMatch = 24'd200;
	localparam logic [MatchW-1:0] LowLimit  = 24'd270000;
	localparam logic [MatchW-1:0] HighLimit = 24'd320000;
	localparam logic [WaitW-1:0]  WaitCap   = 10'd900;
	localparam logic [WaitW-1:0]  WaitBase  = 10'd50;
	localparam logic [WaitW-1:0]  CalWait   = 10'd500;

	localparam logic [MatchW-1:0] ZeroReset  = 24'd304000;
	localparam logic [MatchW-1:0] MatchReset = 24'd296000;
	// Scale for the reset span 288000 - 304000 = -16000: quotient 88, fraction 58255.
	localparam logic [ScaleW-1:0] ScaleReset = 33'd5825423;

	// ceil(2^28 / 45): exact floor division by 45 for values below 2^22.
	localparam logic [22:0] Recip45    = 23'd5965233;
	localparam int          RecipShift = 28;

	typedef struct packed {
		logic              neg;
		logic [MatchW-1:0] mag;
	} sapc_span_t;

	typedef struct packed {
		logic              neg;
		logic [ScaleW-1:0] g;
	} sapc_scale_t;

	typedef struct packed {
		logic [MatchW-1:0] match_value;
		logic [DegW-1:0]   position_degrees;
		logic [WaitW-1:0]  wait_ms;
		logic [PhaseW-1:0] cal_phase;
		logic              rejected;
	} sapc_result_t;

endpackage

// ===== rtl/core/sapc_cmd_if.sv =====
// ----------------------------------------------------------------------------
// sapc_cmd_if: command channel
// Carries one servo command word with its valid/ready handshake.
// ----------------------------------------------------------------------------
interface sapc_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [sapc_pkg::CmdW-1:0]  cmd;
	logic [sapc_pkg::DegW-1:0]  degrees;

	modport source (output valid, output cmd, output degrees, input ready);
	modport sink   (input valid, input cmd, input degrees, output ready);
endinterface

// ===== rtl/core/sapc_res_if.sv =====
// ----------------------------------------------------------------------------
// sapc_res_if: result channel
// Carries one result word with its valid/ready handshake.
// ----------------------------------------------------------------------------
interface sapc_res_if;
	logic                         valid;
	logic                         ready;
	logic [sapc_pkg::MatchW-1:0]  match_value;
	logic [sapc_pkg::DegW-1:0]    position_degrees;
	logic [sapc_pkg::WaitW-1:0]   wait_ms;
	logic [sapc_pkg::PhaseW-1:0]  cal_phase;
	logic                         rejected;

	modport source (output valid, output match_value, output position_degrees,
		output wait_ms, output cal_phase, output rejected, input ready);
	modport sink   (input valid, input match_value, input position_degrees,
		input wait_ms, input cal_phase, input rejected, output ready);
endinterface

// ===== rtl/core/sapc_span_prep.sv =====
// ----------------------------------------------------------------------------
// sapc_span_prep: calibration scale preparation
// Turns a new calibration span into ceil(|span| * 2^16 / 180) in two steps.
// ----------------------------------------------------------------------------
module sapc_span_prep (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  sapc_pkg::sapc_span_t  span,
	output sapc_pkg::sapc_scale_t scale,
	output logic                  busy
);

	localparam logic [1:0] PrepIdle = 2'd0;
	localparam logic [1:0] PrepQuot = 2'd1;
	localparam logic [1:0] PrepFrac = 2'd2;

	logic [1:0]                   state_q;
	logic [sapc_pkg::MatchW-1:0]  mag_q;
	logic                         neg_q;
	logic [sapc_pkg::QuotW-1:0]   quot_q;
	logic [sapc_pkg::ScaleW-1:0]  g_q;

	logic [44:0]                  quot_prod;
	logic [24:0]                  quot_x180;
	logic [7:0]                   rem;
	logic [21:0]                  frac_num;
	logic [44:0]                  frac_prod;

	// |span| / 180 = (|span| / 4) / 45.
	assign quot_prod = 45'(mag_q[sapc_pkg::MatchW-1:2]) * 45'(sapc_pkg::Recip45);
	assign quot_x180 = 25'(quot_q) * 25'(sapc_pkg::MaxDeg);
	assign rem       = 8'(25'(mag_q) - quot_x180);
	// The fraction is rounded up: ceil(rem * 2^16 / 180) = floor((rem * 2^14 + 44) / 45).
	// Rounding up keeps the later floor of deg * g / 2^16 exact when the
	// quotient deg * span / 180 has no remainder.
	assign frac_num  = {rem, 14'b0} + 22'd44;
	assign frac_prod = 45'(frac_num) * 45'(sapc_pkg::Recip45);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PrepIdle;
			neg_q   <= 1'b1;
			g_q     <= sapc_pkg::ScaleReset;
		end else begin
			case (state_q)
				PrepIdle: begin
					if (start) begin
						state_q <= PrepQuot;
						neg_q   <= span.neg;
					end
				end
				PrepQuot: begin
					state_q <= PrepFrac;
				end
				PrepFrac: begin
					state_q <= PrepIdle;
					g_q     <= {quot_q,
						frac_prod[sapc_pkg::RecipShift+sapc_pkg::FracW-1:sapc_pkg::RecipShift]};
				end
				default: begin
					state_q <= PrepIdle;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == PrepIdle) begin
			mag_q <= span.mag;
		end
		if (state_q == PrepQuot) begin
			quot_q <= quot_prod[44:sapc_pkg::RecipShift];
		end
	end

	assign scale.neg = neg_q;
	assign scale.g   = g_q;
	assign busy      = (state_q != PrepIdle);

endmodule

// ===== rtl/core/sapc_interp.sv =====
// ----------------------------------------------------------------------------
// sapc_interp: angle to match interpolation
// match = zero + trunc(span * deg / 180), using the prepared scale.
// ----------------------------------------------------------------------------
module sapc_interp (
	input  logic [sapc_pkg::MatchW-1:0] zero,
	input  sapc_pkg::sapc_scale_t       scale,
	input  logic [sapc_pkg::DegW-1:0]   deg,
	output logic [sapc_pkg::MatchW-1:0] match
);

	logic [40:0]                 prod;
	logic [sapc_pkg::MatchW-1:0] q_mag;
	logic [sapc_pkg::MatchW-1:0] q_signed;

	// The scale is rounded up and keeps enough fraction bits that the floor is
	// exact for deg up to 180.
	assign prod     = 41'(deg) * 41'(scale.g);
	assign q_mag    = prod[39:sapc_pkg::FracW];
	assign q_signed = scale.neg ? (~q_mag + 24'd1) : q_mag;
	assign match    = zero + q_signed;

endmodule

// ===== rtl/core/servo_angle_pulse_calibrator.sv =====
// ----------------------------------------------------------------------------
// servo_angle_pulse_calibrator: servo command to PWM match value
// Executes move and two-point calibration commands, one result per command.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the command channel (cmd, degrees) and each one
// yields exactly one word on the result channel: match value, position, settle
// wait, calibration phase and a rejected flag. A word is moved at a rising
// clock edge where valid and ready are both high.
// The result is registered in the output register, or in the skid buffer while
// an output word is held. Throughput: one command per cycle while command ready
// is high; the interpolation multiply and the state update need no extra step.
// The one exception is a set command that stores a new calibration: the
// scale ceil(|span| * 2^16 / 180) is rebuilt by a two-step prep unit, and
// command ready stays low until the quotient and fraction steps are done.
// Stalls: an output register plus a one-word skid buffer lets the block take
// one more command while a result waits; ready also drops when both hold data.
// Reset (arst_n low) restores the default calibration (304000 at 0 degrees,
// 288000 at 180 degrees), 90 degrees at match 296000, phase idle, and empties
// the output buffers.
// ----------------------------------------------------------------------------
module servo_angle_pulse_calibrator (
	input  logic             clk,
	input  logic             arst_n,
	sapc_cmd_if.sink         command,
	sapc_res_if.source       result
);

	// Architectural state.
	logic [sapc_pkg::MatchW-1:0] zero_q;
	logic [sapc_pkg::MatchW-1:0] match_q;
	logic [sapc_pkg::MatchW-1:0] capt_q;
	logic [sapc_pkg::DegW-1:0]   angle_q;
	logic [sapc_pkg::PhaseW-1:0] phase_q;

	// Output register and skid stage.
	logic                        out_valid_q;
	sapc_pkg::sapc_result_t      out_q;
	logic                        skid_valid_q;
	sapc_pkg::sapc_result_t      skid_q;

	logic                        accept;
	logic                        prep_busy;
	sapc_pkg::sapc_scale_t       scale;
	sapc_pkg::sapc_span_t        new_span;

	logic                        cal;
	logic [sapc_pkg::DegW-1:0]   deg_clamped;
	logic [sapc_pkg::DegW-1:0]   interp_deg;
	logic [sapc_pkg::MatchW-1:0] interp_match;
	logic [sapc_pkg::DegW-1:0]   move_target;
	logic [sapc_pkg::DegW-1:0]   move_diff;
	logic [sapc_pkg::WaitW-1:0]  move_wait_raw;
	logic [sapc_pkg::WaitW-1:0]  move_wait;
	logic [24:0]                 span_diff;
	logic [sapc_pkg::MatchW-1:0] half_mag;
	logic [sapc_pkg::MatchW-1:0] half_match;

	logic [sapc_pkg::MatchW-1:0] nxt_match;
	logic [sapc_pkg::DegW-1:0]   nxt_angle;
	logic [sapc_pkg::PhaseW-1:0] nxt_phase;
	logic [sapc_pkg::WaitW-1:0]  nxt_wait;
	logic                        nxt_rej;
	logic                        capt_we;
	logic                        store;
	sapc_pkg::sapc_result_t      res;

	assign command.ready = !skid_valid_q && !prep_busy;
	assign accept        = command.valid && command.ready;

	assign cal = (phase_q == sapc_pkg::PhaseZero) || (phase_q == sapc_pkg::PhaseFull);

	assign deg_clamped = (command.degrees > sapc_pkg::MaxDeg) ? sapc_pkg::MaxDeg
		: command.degrees;

	// Begin recenters at 90 degrees with the stored calibration.
	assign interp_deg = (command.cmd == sapc_pkg::CmdBegin) ? sapc_pkg::MidDeg : deg_clamped;

	sapc_interp u_interp (
		.zero  (zero_q),
		.scale (scale),
		.deg   (interp_deg),
		.match (interp_match)
	);

	// Settle wait: 50 ms plus 5 ms per degree moved, capped at 900 ms.
	assign move_target   = (command.cmd == sapc_pkg::CmdSet) ? sapc_pkg::MidDeg : deg_clamped;
	assign move_diff     = (move_target > angle_q) ? (move_target - angle_q)
		: (angle_q - move_target);
	assign move_wait_raw = sapc_pkg::WaitBase + {move_diff, 2'b00} + 10'(move_diff);
	assign move_wait     = (move_wait_raw > sapc_pkg::WaitCap) ? sapc_pkg::WaitCap
		: move_wait_raw;

	// New calibration on the final set: span = full - zero, taken as signed.
	assign span_diff    = {1'b0, match_q} - {1'b0, capt_q};
	assign new_span.neg = span_diff[24];
	assign new_span.mag = span_diff[24] ? 24'(~span_diff + 25'd1) : span_diff[23:0];

	// The move to 90 degrees after the final set is zero + trunc(span / 2).
	assign half_mag   = {1'b0, new_span.mag[sapc_pkg::MatchW-1:1]};
	assign half_match = capt_q + (new_span.neg ? (~half_mag + 24'd1) : half_mag);

	always_comb begin
		nxt_match = match_q;
		nxt_angle = angle_q;
		nxt_phase = phase_q;
		nxt_wait  = '0;
		nxt_rej   = 1'b0;
		capt_we   = 1'b0;
		store     = 1'b0;
		case (command.cmd)
			sapc_pkg::CmdMove: begin
				if (cal) begin
					nxt_rej = 1'b1;
				end else begin
					nxt_match = interp_match;
					nxt_angle = deg_clamped;
					nxt_wait  = move_wait;
				end
			end
			sapc_pkg::CmdBegin: begin
				if (cal) begin
					nxt_rej = 1'b1;
				end else begin
					nxt_match = interp_match;
					nxt_angle = sapc_pkg::MidDeg;
					nxt_phase = sapc_pkg::PhaseZero;
					nxt_wait  = sapc_pkg::CalWait;
				end
			end
			sapc_pkg::CmdDown: begin
				if (!cal) begin
					nxt_rej = 1'b1;
				end else if (match_q > sapc_pkg::LowLimit) begin
					nxt_match = match_q - sapc_pkg::StepMatch;
				end
			end
			sapc_pkg::CmdUp: begin
				if (!cal) begin
					nxt_rej = 1'b1;
				end else if (match_q < sapc_pkg::HighLimit) begin
					nxt_match = match_q + sapc_pkg::StepMatch;
				end
			end
			sapc_pkg::CmdSet: begin
				if (!cal) begin
					nxt_rej = 1'b1;
				end else if (phase_q == sapc_pkg::PhaseZero) begin
					capt_we   = 1'b1;
					nxt_phase = sapc_pkg::PhaseFull;
				end else begin
					store     = 1'b1;
					nxt_phase = sapc_pkg::PhaseIdle;
					nxt_match = half_match;
					nxt_angle = sapc_pkg::MidDeg;
					nxt_wait  = move_wait;
				end
			end
			default: begin
				nxt_rej = 1'b1;
			end
		endcase
	end

	sapc_span_prep u_span_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && store),
		.span   (new_span),
		.scale  (scale),
		.busy   (prep_busy)
	);

	assign res.match_value      = nxt_match;
	assign res.position_degrees = nxt_angle;
	assign res.wait_ms          = nxt_wait;
	assign res.cal_phase        = nxt_phase;
	assign res.rejected         = nxt_rej;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q  <= sapc_pkg::ZeroReset;
			match_q <= sapc_pkg::MatchReset;
			capt_q  <= sapc_pkg::ZeroReset;
			angle_q <= sapc_pkg::MidDeg;
			phase_q <= sapc_pkg::PhaseIdle;
		end else if (accept) begin
			match_q <= nxt_match;
			angle_q <= nxt_angle;
			phase_q <= nxt_phase;
			if (capt_we) begin
				capt_q <= match_q;
			end
			if (store) begin
				zero_q <= capt_q;
			end
		end
	end

	// Output register with a one-word skid stage behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !result.ready) begin
			if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !result.ready) begin
			if (accept) begin
				skid_q <= res;
			end
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else if (accept) begin
			out_q <= res;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.match_value      = out_q.match_value;
	assign result.position_degrees = out_q.position_degrees;
	assign result.wait_ms          = out_q.wait_ms;
	assign result.cal_phase        = out_q.cal_phase;
	assign result.rejected         = out_q.rejected;

	// The skid stage only fills behind a held output word.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a word while the output register is empty");

	// Storing a calibration must block commands while the scale is rebuilt.
	a_store_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && store) |=> !command.ready)
		else $error("command accepted while the calibration scale is stale");

	// The unused phase code is never reached.
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sapc_pkg::PhaseIdle) || cal)
		else $error("calibration phase register holds an unused code");

	// While calibrating, the servo stays at the middle angle.
	a_cal_mid_angle: assert property (@(posedge clk) disable iff (!arst_n)
		cal |-> (angle_q == sapc_pkg::MidDeg))
		else $error("angle moved away from 90 degrees during calibration");

	// Delivered results respect the angle and wait limits.
	a_result_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.position_degrees <= sapc_pkg::MaxDeg)
			&& (result.wait_ms <= sapc_pkg::WaitCap))
		else $error("result angle or wait out of range");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for servo_angle_pulse_calibrator
// Sends move and calibration command words through the command channel and
// checks every result word against a cycle-free model of the servo state.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sapc_pkg::*;

	// Command codes 5 to 7 have no meaning and must always be rejected.
	localparam logic [CmdW-1:0] CmdSpare5 = 3'd5;
	localparam logic [CmdW-1:0] CmdSpare6 = 3'd6;
	localparam logic [CmdW-1:0] CmdSpare7 = 3'd7;

	// Default 180-degree point and the settle time added per degree of travel.
	localparam logic [MatchW-1:0] FullReset  = 24'd288000;
	localparam int unsigned       WaitPerDeg = 5;

	localparam int DirectedRows  = 26;
	localparam int StageWords    = 234;  // random command words per idling stage
	localparam int HoldOffCycles = 48;   // long receiver stall to fill the block
	localparam int DrainCycles   = 8;    // extra cycles to watch for stray result words after the drain
	localparam int StuckLimit    = 2000; // cycles with no word moved on either side

	// One row of the directed table. When typed is set, want is the result
	// that the row must produce; otherwise the servo model supplies it.
	typedef struct packed {
		logic [CmdW-1:0] cmd;
		logic [DegW-1:0] deg;
		bit              typed;
		sapc_result_t    want;
	} servo_row_t;

	// Directed part. It starts from the reset calibration (304000 at 0 degrees,
	// 288000 at 180 degrees), so the rows before the first stored calibration
	// can be typed in directly.
	servo_row_t directed_rows [DirectedRows] = '{
		// Moves at the ends of the range, clamping above 180 and the wait cap.
		'{CmdMove,   8'd90,  1'b1, '{24'd296000, 8'd90,  10'd50,  PhaseIdle, 1'b0}},
		'{CmdMove,   8'd0,   1'b1, '{24'd304000, 8'd0,   10'd500, PhaseIdle, 1'b0}},
		'{CmdMove,   8'd255, 1'b1, '{24'd288000, 8'd180, 10'd900, PhaseIdle, 1'b0}},
		'{CmdMove,   8'd181, 1'b1, '{24'd288000, 8'd180, 10'd50,  PhaseIdle, 1'b0}},
		// Buttons, set and unknown codes while idle are rejected.
		'{CmdDown,   8'd0,   1'b1, '{24'd288000, 8'd180, 10'd0,   PhaseIdle, 1'b1}},
		'{CmdUp,     8'd255, 1'b1, '{24'd288000, 8'd180, 10'd0,   PhaseIdle, 1'b1}},
		'{CmdSet,    8'd0,   1'b1, '{24'd288000, 8'd180, 10'd0,   PhaseIdle, 1'b1}},
		'{CmdSpare5, 8'd255, 1'b1, '{24'd288000, 8'd180, 10'd0,   PhaseIdle, 1'b1}},
		'{CmdSpare6, 8'd0,   1'b1, '{24'd288000, 8'd180, 10'd0,   PhaseIdle, 1'b1}},
		'{CmdSpare7, 8'd255, 1'b1, '{24'd288000, 8'd180, 10'd0,   PhaseIdle, 1'b1}},
		// Odd angles: the negative span makes the division truncate toward zero.
		'{CmdMove,   8'd1,   1'b0, '0},
		'{CmdMove,   8'd179, 1'b0, '0},
		// Calibration begins at 90 degrees with a half-second wait.
		'{CmdBegin,  8'd0,   1'b1, '{24'd296000, 8'd90,  10'd500, PhaseZero, 1'b0}},
		// Moves, a second begin and unknown codes are rejected while calibrating.
		'{CmdMove,   8'd0,   1'b1, '{24'd296000, 8'd90,  10'd0,   PhaseZero, 1'b1}},
		'{CmdBegin,  8'd255, 1'b1, '{24'd296000, 8'd90,  10'd0,   PhaseZero, 1'b1}},
		'{CmdSpare7, 8'd0,   1'b1, '{24'd296000, 8'd90,  10'd0,   PhaseZero, 1'b1}},
		// Buttons, then capture the zero point and the full point.
		'{CmdUp,     8'd0,   1'b0, '0},
		'{CmdDown,   8'd0,   1'b0, '0},
		'{CmdSet,    8'd0,   1'b0, '0},
		'{CmdDown,   8'd0,   1'b0, '0},
		'{CmdSet,    8'd0,   1'b0, '0},
		// A calibration with both points equal leaves a span of zero.
		'{CmdBegin,  8'd0,   1'b0, '0},
		'{CmdSet,    8'd0,   1'b0, '0},
		'{CmdSet,    8'd0,   1'b0, '0},
		'{CmdMove,   8'd255, 1'b0, '0},
		'{CmdMove,   8'd37,  1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	sapc_cmd_if cmd_ch ();
	sapc_res_if res_ch ();

	servo_angle_pulse_calibrator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.command(cmd_ch),
		.result (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Servo model state. It starts at the reset values; reset is applied only
	// once, before the first command word.
	logic [MatchW-1:0] zero_cal_match  = ZeroReset;
	logic [MatchW-1:0] full_cal_match  = FullReset;
	logic [MatchW-1:0] held_zero_match = ZeroReset;
	logic [MatchW-1:0] servo_match     = MatchReset;
	logic [DegW-1:0]   servo_angle     = MidDeg;
	logic [PhaseW-1:0] servo_phase     = PhaseIdle;

	sapc_result_t expected_results [$];
	sapc_result_t oldest_result;

	int          fail_count = 0;
	int          words_sent = 0;
	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	bit          hold_request = 1'b0;
	int unsigned stall_left;
	int unsigned quiet_cycles;

	// Linear interpolation between the two calibration points. The span is
	// signed, and the division by 180 truncates toward zero.
	function automatic logic [MatchW-1:0] interp_match(logic [DegW-1:0] deg);
		logic [DegW-1:0] clamped;
		longint          span;
		longint          offset;
		clamped = (deg > MaxDeg) ? MaxDeg : deg;
		span    = longint'(full_cal_match) - longint'(zero_cal_match);
		offset  = (span * longint'(clamped)) / longint'(MaxDeg);
		return MatchW'(longint'(zero_cal_match) + offset);
	endfunction

	// Moves the servo and returns the settle time: a base plus a share per
	// degree of travel, capped.
	function automatic logic [WaitW-1:0] settle_after_move(logic [DegW-1:0] deg);
		logic [DegW-1:0] target;
		int unsigned     travel;
		int unsigned     settle;
		target      = (deg > MaxDeg) ? MaxDeg : deg;
		travel      = 32'((target > servo_angle) ? target - servo_angle
			: servo_angle - target);
		servo_match = interp_match(target);
		servo_angle = target;
		settle      = 32'(WaitBase) + travel * WaitPerDeg;
		if (settle > 32'(WaitCap)) begin
			settle = 32'(WaitCap);
		end
		return WaitW'(settle);
	endfunction

	// Applies one command word to the servo model and returns its result word.
	function automatic sapc_result_t servo_step(logic [CmdW-1:0] c, logic [DegW-1:0] d);
		sapc_result_t r;
		logic         calibrating;
		r           = '0;
		calibrating = (servo_phase == PhaseZero) || (servo_phase == PhaseFull);
		case (c)
			CmdMove: begin
				if (calibrating) r.rejected = 1'b1;
				else r.wait_ms = settle_after_move(d);
			end
			CmdBegin: begin
				if (calibrating) begin
					r.rejected = 1'b1;
				end else begin
					servo_match = interp_match(MidDeg);
					servo_angle = MidDeg;
					servo_phase = PhaseZero;
					r.wait_ms   = CalWait;
				end
			end
			CmdDown: begin
				if (!calibrating) r.rejected = 1'b1;
				else if (servo_match > LowLimit) servo_match = servo_match - StepMatch;
			end
			CmdUp: begin
				if (!calibrating) r.rejected = 1'b1;
				else if (servo_match < HighLimit) servo_match = servo_match + StepMatch;
			end
			CmdSet: begin
				if (!calibrating) begin
					r.rejected = 1'b1;
				end else if (servo_phase == PhaseZero) begin
					held_zero_match = servo_match;
					servo_phase     = PhaseFull;
				end else begin
					// Store both points, leave calibration and return to 90 degrees.
					zero_cal_match = held_zero_match;
					full_cal_match = servo_match;
					servo_phase    = PhaseIdle;
					r.wait_ms      = settle_after_move(MidDeg);
				end
			end
			default: begin
				r.rejected = 1'b1;
			end
		endcase
		r.match_value      = servo_match;
		r.position_degrees = servo_angle;
		r.cal_phase        = servo_phase;
		return r;
	endfunction

	// Offers one command word after a random gap and waits until the block
	// takes it. The model is stepped at the edge where the word moves.
	task automatic send_word(input logic [CmdW-1:0] c, input logic [DegW-1:0] d,
			input bit typed, input sapc_result_t want);
		sapc_result_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.cmd     <= c;
		cmd_ch.degrees <= d;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = servo_step(c, d);
		expected_results.push_back(typed ? want : predicted);
		words_sent++;
	endtask

	task automatic send_cmd(input logic [CmdW-1:0] c, input logic [DegW-1:0] d);
		send_word(c, d, 1'b0, '0);
	endtask

	// Angles lean toward the ends of the range and toward values above 180.
	function automatic logic [DegW-1:0] pick_angle();
		int unsigned pick;
		pick = $urandom_range(9);
		case (pick)
			0: return '0;
			1: return MaxDeg;
			2: return 8'hFF;
			3: return DegW'($urandom_range(255, 181));
			default: return DegW'($urandom_range(180));
		endcase
	endfunction

	// A command that does not belong in a calibration phase.
	function automatic logic [CmdW-1:0] off_phase_cmd();
		int unsigned pick;
		pick = $urandom_range(3);
		case (pick)
			0: return CmdMove;
			1: return CmdBegin;
			2: return CmdSpare5;
			default: return CmdSpare7;
		endcase
	endfunction

	// Button presses. Now and then a long run in one direction drives the
	// match toward its lower or upper limit and can keep pressing there.
	task automatic button_run();
		int unsigned     presses;
		logic [CmdW-1:0] dir;
		if ($urandom_range(15) == 0) begin
			presses = $urandom_range(160, 110);
			dir     = $urandom_range(1) ? CmdUp : CmdDown;
			repeat (presses) send_cmd(dir, DegW'($urandom_range(255)));
		end else begin
			presses = $urandom_range(8);
			repeat (presses) send_cmd($urandom_range(1) ? CmdUp : CmdDown,
				DegW'($urandom_range(255)));
		end
	endtask

	// A full calibration: begin, adjust, capture zero, adjust, capture full.
	// A stray command in between checks that rejection leaves the phase alone.
	task automatic calibration_pass();
		send_cmd(CmdBegin, pick_angle());
		button_run();
		if ($urandom_range(9) == 0) send_cmd(off_phase_cmd(), pick_angle());
		send_cmd(CmdSet, DegW'($urandom_range(255)));
		button_run();
		if ($urandom_range(9) == 0) send_cmd(off_phase_cmd(), pick_angle());
		send_cmd(CmdSet, DegW'($urandom_range(255)));
	endtask

	// One random burst: a run of moves, a calibration, or a random word.
	task automatic random_burst();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			repeat ($urandom_range(8, 1)) send_cmd(CmdMove, pick_angle());
		end else if (pick < 85) begin
			calibration_pass();
		end else begin
			send_cmd(CmdW'($urandom_range(7)), DegW'($urandom_range(255)));
		end
	endtask

	// Result receiver. Ready drops at random; on request it holds off for a
	// long stretch while the sender keeps offering, so the output register and
	// the skid buffer fill and command ready falls.
	initial begin
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				stall_left   = HoldOffCycles;
				hold_request = 1'b0;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Result checker: every result word is compared with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: stray result: expected nothing, actual %0d %0d %0d %0d %0d",
					$time, res_ch.match_value, res_ch.position_degrees, res_ch.wait_ms,
					res_ch.cal_phase, res_ch.rejected);
				fail_count++;
			end else begin
				oldest_result = expected_results.pop_front();
				check_field("match_value", 32'(oldest_result.match_value),
					32'(res_ch.match_value));
				check_field("position_degrees", 32'(oldest_result.position_degrees),
					32'(res_ch.position_degrees));
				check_field("wait_ms", 32'(oldest_result.wait_ms), 32'(res_ch.wait_ms));
				check_field("cal_phase", 32'(oldest_result.cal_phase), 32'(res_ch.cal_phase));
				check_field("rejected", 32'(oldest_result.rejected), 32'(res_ch.rejected));
			end
		end
	end

	// Watchdog: ends the run when no word has moved on either channel for a
	// long time.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < StuckLimit) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("%0t: no word moved for %0d cycles", $time, StuckLimit);
		$display("CHECK FAILED");
		$finish;
	end

	// Main sequence: reset, the directed table, then three stages of random
	// bursts with different idling on each side.
	initial begin
		arst_n         <= 1'b0;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.cmd     <= CmdMove;
		cmd_ch.degrees <= '0;
		src_idle_pct  = 32;
		sink_idle_pct = 47;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].cmd, directed_rows[i].deg, directed_rows[i].typed,
				directed_rows[i].want);
		end

		for (int stage = 0; stage < 3; stage++) begin
			case (stage)
				0: begin
					src_idle_pct  = 32;
					sink_idle_pct = 47;
				end
				1: begin
					src_idle_pct  = 47;
					sink_idle_pct = 32;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			// Long receiver stall at the start of the first and last stage.
			if (stage != 1) hold_request = 1'b1;
			while (words_sent < DirectedRows + (stage + 1) * StageWords) random_burst();
		end
		cmd_ch.valid <= 1'b0;

		// Let the outstanding results drain, then watch for stray words.
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (fail_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sapc_pkg.sv
rtl/core/sapc_cmd_if.sv
rtl/core/sapc_res_if.sv
rtl/core/sapc_span_prep.sv
rtl/core/sapc_interp.sv
rtl/core/servo_angle_pulse_calibrator.sv
dv/tb.sv
